// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/psdd_pkg.sv =====
// Types, constants and codes of the probe spike device detector.
package psdd_pkg;

  localparam int unsigned MAX_DEVICES = 16;
  localparam int unsigned IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEVICES + 1);
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam int unsigned PROD_W = 48;
  localparam int unsigned STEP_W = $clog2(PROD_W + 1);
  localparam int unsigned IN_W = 64;
  localparam int unsigned OUT_W = 56;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_START = 2'd1,
    CMD_PROBE = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BASE   = 2'd1,
    PH_WATCH  = 2'd2,
    PH_RESULT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_BASELINE_MS = 2'd0,
    REG_WATCH_MS    = 2'd1,
    REG_MIN_SPIKE   = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_EVAL,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic clear_tbl;
    logic set_idle;
    logic set_base;
    logic to_watch;
    logic to_result;
    logic idx_clr;
    logic idx_inc;
    logic init_pick;
    logic bump;
    logic add_entry;
    logic set_drop;
    logic mul;
    logic div_step;
    logic eval;
    logic load_out;
  } dp_ctl_t;

  typedef struct packed {
    cmd_e   cmd;
    phase_e phase;
    logic   scan_end;
    logic   match;
    logic   full;
    logic   base_due;
    logic   watch_due;
    logic   div_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/psdd_dp.sv =====
// Datapath: device table, phase timing, divider and winner selection.
module psdd_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [psdd_pkg::IN_W-1:0] in_data_i,
  input  logic [1:0]               in_cmd_i,
  input  logic                     cfg_valid_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  input  psdd_pkg::dp_ctl_t        ctl_i,
  output psdd_pkg::dp_sts_t        sts_o,
  output logic [psdd_pkg::OUT_W-1:0] out_data_o
);
  import psdd_pkg::*;

  logic [31:0] baseline_ms_q, watch_ms_q;
  logic [15:0] min_spike_q;

  cmd_e        cmd_q;
  logic [31:0] fp_q, now_q;
  phase_e      phase_q;
  logic [31:0] start_q;
  logic [CNT_W-1:0] count_q, idx_q;
  logic        drop_q;

  logic [31:0] tbl_fp [MAX_DEVICES];
  logic [15:0] tbl_bc [MAX_DEVICES];
  logic [15:0] tbl_wc [MAX_DEVICES];

  logic [PROD_W-1:0] prod_q;
  logic [31:0]       rem_q;
  logic [STEP_W-1:0] step_q;

  logic [15:0] best_q, best_wc_q;
  logic [31:0] best_fp_q;
  logic        win_q;
  logic [OUT_W-1:0] out_q;

  logic [IDX_W-1:0] ridx;
  logic [31:0]      rd_fp, elapsed;
  logic [15:0]      rd_bc, rd_wc;
  logic [32:0]      trial;
  logic             fits;
  logic [16:0]      expected;
  logic signed [17:0] spike;
  logic             better;

  assign ridx    = idx_q[IDX_W-1:0];
  assign rd_fp   = tbl_fp[ridx];
  assign rd_bc   = tbl_bc[ridx];
  assign rd_wc   = tbl_wc[ridx];
  assign elapsed = now_q - start_q;

  // one restoring division step: quotient bits shift into prod_q
  assign trial = {rem_q, prod_q[PROD_W-1]};
  assign fits  = trial >= {1'b0, baseline_ms_q};

  // expectation above 65536 already loses, so clamp it there
  always_comb begin
    if ((|prod_q[PROD_W-1:17]) || (prod_q[16] && (|prod_q[15:0]))) begin
      expected = 17'h10000;
    end else begin
      expected = prod_q[16:0];
    end
  end

  assign spike  = $signed({2'b00, rd_wc}) - $signed({1'b0, expected});
  assign better = spike > $signed({2'b00, best_q});

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.phase     = phase_q;
    sts_o.scan_end  = idx_q == count_q;
    sts_o.match     = rd_fp == fp_q;
    sts_o.full      = count_q == CNT_W'(MAX_DEVICES);
    sts_o.base_due  = elapsed >= baseline_ms_q;
    sts_o.watch_due = elapsed >= watch_ms_q;
    sts_o.div_done  = step_q == STEP_W'(PROD_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_ms_q <= 32'd10000;
      watch_ms_q    <= 32'd10000;
      min_spike_q   <= 16'd3;
      cmd_q         <= CMD_RESET;
      phase_q       <= PH_IDLE;
      start_q       <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      drop_q        <= 1'b0;
      win_q         <= 1'b0;
      best_q        <= '0;
      step_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_BASELINE_MS: baseline_ms_q <= cfg_data_i;
          REG_WATCH_MS:    watch_ms_q    <= cfg_data_i;
          REG_MIN_SPIKE:   min_spike_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (ctl_i.capture) begin
        cmd_q  <= cmd_e'(in_cmd_i);
        drop_q <= 1'b0;
      end
      if (ctl_i.clear_tbl) begin
        count_q <= '0;
        win_q   <= 1'b0;
      end
      if (ctl_i.set_idle) begin
        phase_q <= PH_IDLE;
        start_q <= '0;
      end
      if (ctl_i.set_base) begin
        phase_q <= PH_BASE;
        start_q <= now_q;
      end
      if (ctl_i.to_watch) begin
        phase_q <= PH_WATCH;
        start_q <= now_q;
      end
      if (ctl_i.idx_clr) idx_q <= '0;
      if (ctl_i.idx_inc) idx_q <= idx_q + 1'b1;
      if (ctl_i.init_pick) begin
        idx_q  <= '0;
        best_q <= '0;
      end
      if (ctl_i.add_entry) count_q <= count_q + 1'b1;
      if (ctl_i.set_drop) drop_q <= 1'b1;
      if (ctl_i.mul) step_q <= '0;
      if (ctl_i.div_step) step_q <= step_q + 1'b1;
      if (ctl_i.eval && better) best_q <= spike[15:0];
      if (ctl_i.to_result) begin
        phase_q <= PH_RESULT;
        win_q   <= (best_q != '0) && (best_q >= min_spike_q);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      fp_q  <= in_data_i[31:0];
      now_q <= in_data_i[63:32];
    end
    if (ctl_i.add_entry) begin
      tbl_fp[ridx] <= fp_q;
      tbl_bc[ridx] <= (phase_q == PH_BASE) ? 16'd1 : 16'd0;
      tbl_wc[ridx] <= (phase_q == PH_WATCH) ? 16'd1 : 16'd0;
    end
    if (ctl_i.bump) begin
      if (phase_q == PH_BASE) begin
        if (rd_bc != CNT_MAX) tbl_bc[ridx] <= rd_bc + 16'd1;
      end else begin
        if (rd_wc != CNT_MAX) tbl_wc[ridx] <= rd_wc + 16'd1;
      end
    end
    if (ctl_i.mul) begin
      prod_q <= PROD_W'({16'd0, rd_bc} * {16'd0, watch_ms_q});
      rem_q  <= '0;
    end
    if (ctl_i.div_step) begin
      prod_q <= {prod_q[PROD_W-2:0], fits};
      rem_q  <= fits ? 32'(trial - {1'b0, baseline_ms_q}) : trial[31:0];
    end
    if (ctl_i.eval && better) begin
      best_fp_q <= rd_fp;
      best_wc_q <= rd_wc;
    end
    if (ctl_i.load_out) begin
      out_q <= {3'b000, drop_q,
                win_q ? best_wc_q : 16'd0,
                win_q ? best_fp_q : 32'd0,
                (phase_q == PH_RESULT) && !win_q,
                phase_q == PH_RESULT,
                phase_q};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/psdd_ctrl.sv =====
// Controller state machine: sequences each command through the datapath.
module psdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  psdd_pkg::dp_sts_t sts_i,
  output psdd_pkg::dp_ctl_t ctl_o
);
  import psdd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = state_q == S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.cmd)
          CMD_RESET: begin
            ctl_o.clear_tbl = 1'b1;
            ctl_o.set_idle  = 1'b1;
          end
          CMD_START: begin
            ctl_o.clear_tbl = 1'b1;
            ctl_o.set_base  = 1'b1;
          end
          CMD_PROBE: begin
            if (sts_i.phase == PH_BASE || sts_i.phase == PH_WATCH) begin
              ctl_o.idx_clr = 1'b1;
              state_d = S_SCAN;
            end
          end
          CMD_TICK: begin
            if (sts_i.phase == PH_BASE && sts_i.base_due) begin
              ctl_o.to_watch = 1'b1;
            end else if (sts_i.phase == PH_WATCH && sts_i.watch_due) begin
              ctl_o.init_pick = 1'b1;
              state_d = S_MUL;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          if (sts_i.full) ctl_o.set_drop = 1'b1;
          else ctl_o.add_entry = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.match) begin
          ctl_o.bump = 1'b1;
          state_d = S_DONE;
        end else begin
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_MUL: begin
        if (sts_i.scan_end) begin
          state_d = S_FIN;
        end else begin
          ctl_o.mul = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_EVAL;
        else ctl_o.div_step = 1'b1;
      end
      S_EVAL: begin
        ctl_o.eval    = 1'b1;
        ctl_o.idx_inc = 1'b1;
        state_d = S_MUL;
      end
      S_FIN: begin
        ctl_o.to_result = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/probe_spike_device_detector.sv =====
// Top level of the probe spike device detector.
// Each input word carries a command in s_axis_tuser (reset, start, probe, tick)
// and fingerprint/now_ms in s_axis_tdata; each accepted word yields exactly one
// output word holding the phase, result flags, winner and drop flag as they
// stand after the command. Reset, start and a tick that runs no winner pick go
// from decode straight to the output. A probe in the baseline or watch phase
// scans the table from entry 0 (one fingerprint compare a cycle, up to 16)
// until it matches an entry or reaches the end, where a new fingerprint is
// added or, with a full table, dropped. The tick that closes the watch phase
// runs the winner pick: per table entry one 16x32 multiply, a 48-step restoring
// divider and one compare. The output register lets a new word enter while the
// previous result still waits. Configuration writes are always taken.
module probe_spike_device_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // fingerprint[31:0], now_ms[63:32]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // phase[1:0], have_result[2], ambiguous[3],
                                      // winner_fingerprint[35:4], winner_probes[51:36],
                                      // probe_dropped[52], zero pad[55:53]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import psdd_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // registers are plain flops: accept a write in any cycle
  assign cfg_ready_o = 1'b1;

  psdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  psdd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/psdd_checker.sv =====
// Port-level checks of the probe spike device detector.
`include "assert_macros.svh"

module psdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // have_result mirrors the result phase
  `ASSERT_PROP(a_have_result, clk_i, rst_ni,
    !m_axis_tvalid || (m_axis_tdata[2] == (m_axis_tdata[1:0] == psdd_pkg::PH_RESULT)))

  // ambiguous only in result phase, and then no winner is shown
  `ASSERT_PROP(a_ambiguous, clk_i, rst_ni,
    !m_axis_tvalid || !m_axis_tdata[3] || (m_axis_tdata[2] && m_axis_tdata[51:36] == 16'd0))

  // a winner has at least one watch probe
  `ASSERT_PROP(a_winner_probes, clk_i, rst_ni,
    !m_axis_tvalid || m_axis_tdata[1:0] != psdd_pkg::PH_RESULT || m_axis_tdata[3] ||
    m_axis_tdata[51:36] != 16'd0)

  // a stalled output word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind probe_spike_device_detector psdd_checker u_psdd_checker (.*);

// ===== tb/tb_probe_spike_device_detector.sv =====
// Testbench of the probe spike device detector: directed table, random sessions, predictor.
`timescale 1ns / 100ps

module tb_probe_spike_device_detector;
  import psdd_pkg::*;

  // One result word as it sits in m_axis_tdata[52:0], lowest field last here.
  typedef struct packed {
    logic        dropped;
    logic [15:0] probes;
    logic [31:0] win_fp;
    logic        amb;
    logic        have;
    phase_e      ph;
  } result_t;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] fp;
    logic [31:0] now;
    bit          typed;
    result_t     want;
  } dir_row_t;

  localparam result_t W_IDLE = '0;
  localparam result_t W_BASE = '{1'b0, 16'd0, 32'd0, 1'b0, 1'b0, PH_BASE};
  localparam result_t W_WIN  = '{1'b0, 16'd4, 32'hFFFF_FFFF, 1'b0, 1'b1, PH_RESULT};
  localparam int unsigned NUM_DIR = 23;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // fingerprint[31:0], now_ms[63:32]
  logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // phase, have_result, ambiguous, winner_fingerprint,
                                    // winner_probes, probe_dropped, zero pad
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  probe_spike_device_detector u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: our own copy of the registers and the device table.
  logic [31:0] cfg_base_ms = 32'd10000;
  logic [31:0] cfg_watch_ms = 32'd10000;
  logic [15:0] cfg_min_spike = 16'd3;
  phase_e      det_phase = PH_IDLE;
  logic [31:0] det_start = '0;
  int unsigned det_count = 0;
  logic [31:0] det_fp [MAX_DEVICES];
  logic [15:0] det_base_cnt [MAX_DEVICES];
  logic [15:0] det_watch_cnt [MAX_DEVICES];
  int unsigned det_win_idx = 0;
  bit          det_win_ok = 0;

  result_t     pending_results [$];
  int          mismatches = 0;
  int          src_idle_pct = 8;
  int          dst_idle_pct = 54;
  bit          hold_request = 0;
  int          hold_left = 0;
  dir_row_t    dir_rows [NUM_DIR];

  // Per-device expectation scaled to the watch length; pick the largest positive spike.
  function automatic void pick_winner();
    longint top_spike;
    longint spike;
    logic [63:0] expect_cnt;
    top_spike = 0;
    det_win_ok = 0;
    det_win_idx = 0;
    for (int i = 0; i < det_count; i++) begin
      if (cfg_base_ms == 0) expect_cnt = 64'd65536;
      else expect_cnt = (64'(det_base_cnt[i]) * 64'(cfg_watch_ms)) / 64'(cfg_base_ms);
      if (expect_cnt > 64'd65536) expect_cnt = 64'd65536;
      spike = longint'(det_watch_cnt[i]) - longint'(expect_cnt);
      if (spike > top_spike) begin
        top_spike = spike;
        det_win_idx = i;
        det_win_ok = 1;
      end
    end
    if (!(det_win_ok && top_spike >= longint'(cfg_min_spike))) begin
      det_win_ok = 0;
      det_win_idx = 0;
    end
  endfunction

  function automatic result_t predict_result(cmd_e cmd, logic [31:0] fp, logic [31:0] now);
    result_t r;
    int hit;
    logic [31:0] elapsed;
    r = '0;
    case (cmd)
      CMD_RESET, CMD_START: begin
        det_count = 0;
        det_win_ok = 0;
        det_win_idx = 0;
        det_phase = (cmd == CMD_START) ? PH_BASE : PH_IDLE;
        det_start = (cmd == CMD_START) ? now : 32'd0;
      end
      CMD_PROBE: begin
        if (det_phase == PH_BASE || det_phase == PH_WATCH) begin
          hit = -1;
          for (int i = 0; i < det_count; i++)
            if (hit < 0 && det_fp[i] == fp) hit = i;
          if (hit < 0) begin
            if (det_count >= MAX_DEVICES) begin
              r.dropped = 1'b1;
            end else begin
              hit = det_count;
              det_fp[hit] = fp;
              det_base_cnt[hit] = '0;
              det_watch_cnt[hit] = '0;
              det_count++;
            end
          end
          if (hit >= 0) begin
            if (det_phase == PH_BASE) begin
              if (det_base_cnt[hit] != CNT_MAX) det_base_cnt[hit]++;
            end else if (det_watch_cnt[hit] != CNT_MAX) begin
              det_watch_cnt[hit]++;
            end
          end
        end
      end
      default: begin
        elapsed = now - det_start;
        if (det_phase == PH_BASE && elapsed >= cfg_base_ms) begin
          det_phase = PH_WATCH;
          det_start = now;
        end else if (det_phase == PH_WATCH && elapsed >= cfg_watch_ms) begin
          pick_winner();
          det_phase = PH_RESULT;
        end
      end
    endcase
    r.ph = det_phase;
    r.have = (det_phase == PH_RESULT);
    r.amb = (det_phase == PH_RESULT) && !det_win_ok;
    r.win_fp = det_win_ok ? det_fp[det_win_idx] : 32'd0;
    r.probes = det_win_ok ? det_watch_cnt[det_win_idx] : 16'd0;
    return r;
  endfunction

  // Offer one word; the handshake is judged at the falling edge and taken at the next rise.
  task automatic send_word(cmd_e cmd, logic [31:0] fp, logic [31:0] now,
                           bit typed = 0, result_t want = '0);
    result_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {now, fp};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    predicted = predict_result(cmd, fp, now);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Write a register only once every pending word has come back.
  task automatic write_reg(reg_e idx, logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BASELINE_MS: cfg_base_ms = value;
      REG_WATCH_MS:    cfg_watch_ms = value;
      default:         cfg_min_spike = value[15:0];
    endcase
  endtask

  // One start/baseline/watch/result run with random content; sometimes broken on purpose.
  task automatic run_session();
    logic [31:0] pool [20];
    logic [31:0] t_now;
    int n_dev;
    int hot;
    n_dev = ($urandom_range(9) < 2) ? $urandom_range(17, 20) : $urandom_range(1, 8);
    for (int i = 0; i < 20; i++) begin
      case ($urandom_range(9))
        0:       pool[i] = 32'd0;
        1:       pool[i] = 32'hFFFF_FFFF;
        default: pool[i] = $urandom;
      endcase
    end
    hot = $urandom_range(n_dev - 1);
    t_now = $urandom;
    send_word(CMD_START, $urandom, t_now);
    repeat ($urandom_range(0, 10)) send_word(CMD_PROBE, pool[$urandom_range(n_dev - 1)], $urandom);
    if (n_dev > 16) for (int i = 0; i < n_dev; i++) send_word(CMD_PROBE, pool[i], $urandom);
    // Break some runs: an early reset or restart, or a stray command.
    if ($urandom_range(9) == 0) send_word(cmd_e'($urandom_range(3)), $urandom, $urandom);
    if ($urandom_range(1)) send_word(CMD_TICK, $urandom, t_now + cfg_base_ms - 32'd1);
    t_now = t_now + cfg_base_ms + $urandom_range(0, 3);
    send_word(CMD_TICK, $urandom, t_now);
    repeat ($urandom_range(0, 8)) send_word(CMD_PROBE, pool[$urandom_range(n_dev - 1)], $urandom);
    repeat ($urandom_range(0, 8)) send_word(CMD_PROBE, pool[hot], $urandom);
    if ($urandom_range(1)) send_word(CMD_TICK, $urandom, t_now + cfg_watch_ms - 32'd1);
    send_word(CMD_TICK, $urandom, t_now + cfg_watch_ms + $urandom_range(0, 3));
    repeat ($urandom_range(0, 2)) send_word(cmd_e'($urandom_range(3)), $urandom, $urandom);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Compare each delivered word with the oldest pending prediction.
  always @(negedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[52:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.ph !== want.ph || got.have !== want.have || got.amb !== want.amb ||
            got.win_fp !== want.win_fp || got.probes !== want.probes ||
            got.dropped !== want.dropped || m_axis_tdata[55:53] !== 3'b000) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp ph=%0d have=%0d amb=%0d fp=%h probes=%0d drop=%0d",
                      " | got ph=%0d have=%0d amb=%0d fp=%h probes=%0d drop=%0d pad=%b"},
                     want.ph, want.have, want.amb, want.win_fp, want.probes, want.dropped,
                     got.ph, got.have, got.amb, got.win_fp, got.probes, got.dropped,
                     m_axis_tdata[55:53]);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    // Default lengths of 10000 ms; the first start sits just below the time wrap.
    dir_rows = '{
      '{CMD_RESET, 32'h0, 32'h0, 1'b1, W_IDLE},
      '{CMD_PROBE, 32'h0, 32'h0, 1'b1, W_IDLE},
      '{CMD_TICK,  32'h0, 32'hFFFF_FFFF, 1'b1, W_IDLE},
      '{CMD_START, 32'h0, 32'hFFFF_FFF0, 1'b1, W_BASE},
      '{CMD_PROBE, 32'h0, 32'h0, 1'b1, W_BASE},
      '{CMD_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b1, W_BASE},
      '{CMD_PROBE, 32'h0, 32'h0, 1'b1, W_BASE},
      '{CMD_TICK,  32'h0, 32'd9983, 1'b1, W_BASE},
      '{CMD_TICK,  32'h0, 32'd9984, 1'b0, W_IDLE},
      '{CMD_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, W_IDLE},
      '{CMD_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, W_IDLE},
      '{CMD_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, W_IDLE},
      '{CMD_PROBE, 32'hFFFF_FFFF, 32'h0, 1'b0, W_IDLE},
      '{CMD_TICK,  32'h0, 32'd19983, 1'b0, W_IDLE},
      '{CMD_TICK,  32'h0, 32'd19984, 1'b1, W_WIN},
      '{CMD_PROBE, 32'h1234, 32'h0, 1'b1, W_WIN},
      '{CMD_TICK,  32'h0, 32'h0, 1'b1, W_WIN},
      '{CMD_START, 32'h0, 32'd5, 1'b1, W_BASE},
      '{CMD_RESET, 32'h0, 32'h0, 1'b1, W_IDLE},
      '{CMD_START, 32'h0, 32'h0, 1'b1, W_BASE},
      '{CMD_TICK,  32'h0, 32'd10000, 1'b0, W_IDLE},
      '{CMD_PROBE, 32'd7, 32'h0, 1'b0, W_IDLE},
      '{CMD_TICK,  32'h0, 32'd20000, 1'b0, W_IDLE}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].fp, dir_rows[i].now,
                dir_rows[i].typed, dir_rows[i].want);

    // Random part: four register settings, idling pattern changes along the way.
    for (int cfg = 0; cfg < 4; cfg++) begin
      case (cfg)
        0: begin
          write_reg(REG_BASELINE_MS, 32'd100);
          write_reg(REG_WATCH_MS, 32'd200);
          write_reg(REG_MIN_SPIKE, 32'd3);
        end
        1: begin
          src_idle_pct = 54;
          dst_idle_pct = 8;
          write_reg(REG_BASELINE_MS, 32'd1);
          write_reg(REG_WATCH_MS, 32'd1);
          write_reg(REG_MIN_SPIKE, 32'd1);
        end
        2: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
          write_reg(REG_BASELINE_MS, 32'hFFFF_FFFF);
          write_reg(REG_WATCH_MS, 32'hFFFF_FFFF);
          write_reg(REG_MIN_SPIKE, 32'd65535);
        end
        default: begin
          write_reg(REG_BASELINE_MS, 32'd1000);
          write_reg(REG_WATCH_MS, 32'd250);
          write_reg(REG_MIN_SPIKE, 32'd2);
        end
      endcase
      for (int s = 0; s < 7; s++) begin
        // Long receiver stall while we keep offering words, so the input backs up.
        if (cfg == 0 && s == 2) hold_request = 1;
        // Pause the sender until every pending word has drained.
        if (cfg == 1 && s == 3) begin
          s_axis_tvalid <= 1'b0;
          wait (pending_results.size() == 0);
          @(posedge clk_i);
        end
        run_session();
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
